### hdl/itf_pkg.sv
package itf_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIGIT,
    ST_PREP,
    ST_LPAD,
    ST_SIGN,
    ST_DIGITS,
    ST_RPAD
  } itf_state_t;

  // Integer kinds
  localparam logic [1:0] KIND_SINT   = 2'd0;
  localparam logic [1:0] KIND_UINT   = 2'd1;
  localparam logic [1:0] KIND_SSHORT = 2'd2;
  localparam logic [1:0] KIND_USHORT = 2'd3;

  // Base selections
  localparam logic [1:0] BASE_OCT  = 2'd0;
  localparam logic [1:0] BASE_DEC  = 2'd1;
  localparam logic [1:0] BASE_HEXL = 2'd2;
  localparam logic [1:0] BASE_HEXU = 2'd3;

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  // ceil(2^35 / 10): (x * RECIP10) >> 35 == x / 10 for every 32-bit x
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  // One digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'b0, d};
    end else if (upper) begin
      c = CHAR_UPPER_A + {4'b0, d} - 8'd10;
    end else begin
      c = CHAR_LOWER_A + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

### hdl/integer_to_text_formatter_core.sv
// Integer to ASCII text formatter.
// Input channel (item_valid / item_stall) takes one value with its kind, base,
// field width and minimum digit count. Output channel (char_valid / char_stall)
// returns the text one character per transfer; last marks the final character.
// item_stall is high from the accepting edge until the sequencer has put the
// final character of the item into the output register.
// Each item has D digits (1..MAX_DIGITS) and T characters in all (at most 63);
// output stalls hold the sequencer while it has a character to load.
// Each digit passes ST_DIV then ST_DIGIT in the shared divide-step unit
// (quotient by reciprocal multiply or shift, then remainder); text leaves at
// one character per cycle while char_stall is low, from a single output
// register. The first character follows the digit loop and ST_PREP.
// Reset returns the sequencer to idle and empties the output register. While
// char_stall is high the held character stays put and no new one is loaded.
module integer_to_text_formatter_core
  import itf_pkg::*;
#(
  parameter int MAX_DIGITS = 28,
  parameter int MAX_WIDTH  = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [31:0]       value,
  input  logic [1:0]        integer_kind,
  input  logic [1:0]        base_select,
  input  logic signed [6:0] field_width,
  input  logic [4:0]        min_digits,
  output logic              char_valid,
  input  logic              char_stall,
  output logic [7:0]        character,
  output logic              last
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int IW = $clog2(MAX_DIGITS);

  itf_state_t state, state_next;

  logic [31:0]   mag;
  logic [1:0]    bsel;
  logic [4:0]    mind;
  logic          neg;
  logic [5:0]    wmag;
  logic          wleft;
  logic [CW-1:0] count;
  logic [IW-1:0] dptr, dptr_next;
  logic [5:0]    padcnt;
  logic          pad_right;

  logic [31:0]   quot;
  logic [3:0]    rem;
  logic [3:0]    rd_data;

  logic          accept;
  logic          out_free;
  logic          load_out;
  logic [7:0]    char_next;
  logic          last_next;
  logic [CW-1:0] cnt_inc;
  logic          digits_done;

  logic [31:0]   v_ext;
  logic          v_neg;
  logic [6:0]    w_abs;
  logic [5:0]    w_sat;

  logic [6:0]    len7;
  logic [6:0]    wide7;
  logic [6:0]    pad7;
  logic          has_pad;
  logic          upper;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !char_valid || !char_stall;
  assign upper      = (bsel == BASE_HEXU);

  // Input decode: short extension, sign, width saturation
  always_comb begin
    v_ext = value;
    if (integer_kind == KIND_SSHORT) begin
      v_ext = {{16{value[15]}}, value[15:0]};
    end else if (integer_kind == KIND_USHORT) begin
      v_ext = {16'b0, value[15:0]};
    end
    v_neg = (integer_kind == KIND_SINT || integer_kind == KIND_SSHORT) && v_ext[31];
    w_abs = field_width[6] ? (7'd0 - field_width) : field_width;
    w_sat = (w_abs > 7'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : w_abs[5:0];
  end

  // Shared divide step and digit store
  itf_divstep u_divstep (
    .clk      (clk),
    .en       (state == ST_DIV),
    .mag      (mag),
    .base_sel (bsel),
    .quot     (quot),
    .rem      (rem)
  );

  itf_digitbuf #(
    .DEPTH (MAX_DIGITS)
  ) u_digitbuf (
    .clk   (clk),
    .we    (state == ST_DIGIT),
    .waddr (count[IW-1:0]),
    .wdata (rem),
    .raddr (dptr_next),
    .rdata (rd_data)
  );

  // Digit loop termination
  assign cnt_inc     = count + CW'(1);
  assign digits_done = (32'(cnt_inc) >= 32'(MAX_DIGITS)) ||
                       ((quot == 32'd0) && (32'(cnt_inc) >= 32'(mind)));

  // Pad length from text length and width magnitude
  assign len7    = 7'(count) + 7'(neg);
  assign wide7   = {1'b0, wmag};
  assign has_pad = (wide7 > len7);
  assign pad7    = wide7 - len7;

  // Next state and output character
  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    char_next  = CHAR_SPACE;
    last_next  = 1'b0;
    dptr_next  = dptr;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        state_next = digits_done ? ST_PREP : ST_DIV;
        // most significant digit is read out first
        if (digits_done) begin
          dptr_next = count[IW-1:0];
        end
      end
      ST_PREP: begin
        if (has_pad && wleft) begin
          state_next = ST_LPAD;
        end else if (neg) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_DIGITS;
        end
      end
      ST_LPAD: begin
        if (out_free) begin
          load_out = 1'b1;
          if (padcnt == 6'd1) begin
            state_next = neg ? ST_SIGN : ST_DIGITS;
          end
        end
      end
      ST_SIGN: begin
        char_next = CHAR_MINUS;
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        char_next = digit_char(rd_data, upper);
        last_next = (dptr == '0) && !pad_right;
        if (out_free) begin
          load_out = 1'b1;
          if (dptr == '0) begin
            state_next = pad_right ? ST_RPAD : ST_IDLE;
          end else begin
            dptr_next = dptr - IW'(1);
          end
        end
      end
      ST_RPAD: begin
        last_next = (padcnt == 6'd1);
        if (out_free) begin
          load_out = 1'b1;
          if (padcnt == 6'd1) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item registers and counters
  always_ff @(posedge clk) begin
    dptr <= dptr_next;
    if (accept) begin
      mag   <= v_neg ? (32'd0 - v_ext) : v_ext;
      neg   <= v_neg;
      bsel  <= base_select;
      mind  <= min_digits;
      wmag  <= w_sat;
      wleft <= !field_width[6];
      count <= '0;
    end
    if (state == ST_DIGIT) begin
      mag   <= quot;
      count <= cnt_inc;
    end
    if (state == ST_PREP) begin
      padcnt    <= has_pad ? pad7[5:0] : 6'd0;
      pad_right <= has_pad && !wleft;
    end
    if ((state == ST_LPAD || state == ST_RPAD) && out_free) begin
      padcnt <= padcnt - 6'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (load_out) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      character <= char_next;
      last      <= last_next;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> item_stall)
    else $error("formatter accepted an item without going busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_DIV) |-> (32'(count) <= 32'(MAX_DIGITS)))
    else $error("digit count beyond limit");

  a_dptr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIGITS) |-> (32'(dptr) < 32'(count)))
    else $error("digit pointer outside stored digits");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LPAD || state == ST_RPAD) |-> (padcnt != 6'd0))
    else $error("pad state entered with no pad left");

endmodule

### hdl/itf_divstep.sv
module itf_divstep
  import itf_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mag,
  input  logic [1:0]  base_sel,
  output logic [31:0] quot,
  output logic [3:0]  rem
);

  logic [63:0] prod;
  logic [31:0] quot_next;
  logic [31:0] qb;
  logic [31:0] diff;

  // Quotient by shift or by reciprocal multiply
  assign prod = {32'b0, mag} * {32'b0, RECIP10};

  always_comb begin
    unique case (base_sel)
      BASE_OCT:  quot_next = {3'b0, mag[31:3]};
      BASE_DEC:  quot_next = {3'b0, prod[63:35]};
      BASE_HEXL: quot_next = {4'b0, mag[31:4]};
      BASE_HEXU: quot_next = {4'b0, mag[31:4]};
      default:   quot_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= quot_next;
    end
  end

  // Remainder from the registered quotient; mag is held by the caller
  always_comb begin
    unique case (base_sel)
      BASE_OCT:  qb = {quot[28:0], 3'b0};
      BASE_DEC:  qb = {quot[28:0], 3'b0} + {quot[30:0], 1'b0};
      BASE_HEXL: qb = {quot[27:0], 4'b0};
      BASE_HEXU: qb = {quot[27:0], 4'b0};
      default:   qb = '0;
    endcase
  end

  assign diff = mag - qb;
  assign rem  = diff[3:0];

endmodule

### hdl/itf_digitbuf.sv
module itf_digitbuf #(
  parameter int DEPTH = 28,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [3:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [3:0]    rdata
);

  logic [3:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
